[design/oswt_pkg.sv]
// ----------------------------------------------------------------------------
// oswt_pkg
// Shared types, constants and helpers of the on/off server with transition.
// ----------------------------------------------------------------------------
package oswt_pkg;

    // Width of the millisecond timers and of the stored transition time.
    localparam int TIME_BITS = 26;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Wide working width for products and sums before saturation.
    localparam int WIDE_BITS = 40;

    localparam int STEP_BITS = 6;
    localparam logic [STEP_BITS-1:0] STEP_FOREVER = 6'h3f;
    localparam logic [7:0] CODE_FOREVER = 8'h3f;

    // Milliseconds per step for the four resolutions of a time code.
    localparam logic [31:0] RES_MS [4] = '{32'd100, 32'd1000, 32'd10000, 32'd600000};

    // Encoder: the value rounded up before division stays below 64 steps of the
    // chosen resolution, so it fits in one bit more than the timer.
    localparam int ENC_BITS = TIME_BITS + 1;
    localparam int RECIP_BITS = ENC_BITS + 2;

    // floor(x / d) == (x * ceil(2^s / d)) >> s for every x below 2^ENC_BITS when
    // s = ENC_BITS + ceil(log2(d)).
    localparam int RES_SHIFT [4] = '{ENC_BITS + 7, ENC_BITS + 10, ENC_BITS + 14,
                                     ENC_BITS + 20};
    localparam logic [63:0] RECIP_FULL [4] = '{
        ((64'd1 << (ENC_BITS + 7)) + 64'd99) / 64'd100,
        ((64'd1 << (ENC_BITS + 10)) + 64'd999) / 64'd1000,
        ((64'd1 << (ENC_BITS + 14)) + 64'd9999) / 64'd10000,
        ((64'd1 << (ENC_BITS + 20)) + 64'd599999) / 64'd600000
    };

    // A time at or above 63 steps of a resolution moves to the next one.
    localparam logic [WIDE_BITS-1:0] ENC_LIMIT [4] = '{
        40'd6300, 40'd63000, 40'd630000, 40'd37800000
    };

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_GET       = 2'd1,
        MODE_SET_ACK   = 2'd2,
        MODE_SET_UNACK = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        KIND_STATUS = 1'b0,
        KIND_UPDATE = 1'b1
    } result_kind_t;

    typedef struct packed {
        mode_t        mode;
        logic         target_value;
        logic [7:0]   transaction_id;
        logic [15:0]  source_address;
        logic         has_timing;
        logic [7:0]   transition_code;
        logic [7:0]   delay_code;
    } item_in_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic         present_value;
        logic         reported_target;
        logic         has_remaining;
        logic [7:0]   remaining_code;
        logic         led_level;
    } result_t;

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [WIDE_BITS-1:0] v);
        logic [TIME_BITS-1:0] r;
        if (v > WIDE_BITS'(TIME_MAX)) begin
            r = TIME_MAX;
        end
        else begin
            r = v[TIME_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[design/onoff_server_with_transition.sv]
// ----------------------------------------------------------------------------
// onoff_server_with_transition
// Generic on/off server: millisecond ticks, get, and set with delay and
// transition timing, answering with status messages and LED updates.
// ----------------------------------------------------------------------------
//  channel | direction | payload   | handshake
//  --------+-----------+-----------+----------------------
//  in      | input     | item_in_t | in_valid / in_ready
//  out     | output    | result_t  | out_valid / out_ready
//
// One transaction per cycle is sustained while the output is not stalled; a result
// passes through the input register, then the result register, before it is offered.
// The set timing codes are decoded into milliseconds in the input register;
// the state update and the status encoding both feed the result register.
// Reset clears all server state: LED off, timer idle, value and identity zero.
// in_ready drops only while the input register is full and a waiting result
// is not taken.
module onoff_server_with_transition (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  oswt_pkg::item_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output oswt_pkg::result_t  out_data
);
    import oswt_pkg::*;

    typedef struct packed {
        mode_t                mode;
        logic                 target_value;
        logic [7:0]           transaction_id;
        logic [15:0]          source_address;
        logic                 is_forever;
        logic [TIME_BITS-1:0] trans_ms;
        logic [TIME_BITS-1:0] delay_ms;
    } stage_t;

    // Input register.
    logic   s1_valid_reg;
    stage_t s1_reg;
    stage_t s1_next;

    // Server state.
    logic                 stored_value_reg, stored_value_next;
    logic [7:0]           last_tid_reg, last_tid_next;
    logic [15:0]          last_src_reg, last_src_next;
    logic [TIME_BITS-1:0] pending_reg, pending_next;
    logic                 forever_reg, forever_next;
    logic [TIME_BITS-1:0] count_reg, count_next;
    logic                 armed_reg, armed_next;
    logic                 led_reg, led_next;

    // Result register.
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;
    logic    produce;

    logic advance;
    logic in_fire;

    logic [STEP_BITS-1:0]     steps;
    logic [STEP_BITS+31:0]    trans_prod;
    logic [10:0]              delay_x5;

    logic                     is_set;
    logic                     take_set;
    logic [TIME_BITS:0]       rem_sum;
    logic [TIME_BITS-1:0]     rem_ms;
    logic [7:0]               rem_code;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Decode the optional timing bytes of a set into milliseconds.
    assign steps      = in_data.transition_code[STEP_BITS-1:0];
    assign trans_prod = (STEP_BITS+32)'(steps) *
                        (STEP_BITS+32)'(RES_MS[in_data.transition_code[7:6]]);
    assign delay_x5   = 11'({in_data.delay_code, 2'b00}) + 11'(in_data.delay_code);

    always_comb begin
        s1_next.mode           = in_data.mode;
        s1_next.target_value   = in_data.target_value;
        s1_next.transaction_id = in_data.transaction_id;
        s1_next.source_address = in_data.source_address;
        s1_next.is_forever     = 1'b0;
        s1_next.trans_ms       = '0;
        s1_next.delay_ms       = '0;
        if (in_data.has_timing) begin
            s1_next.delay_ms = sat_time(WIDE_BITS'(delay_x5));
            if (steps == STEP_FOREVER) begin
                s1_next.is_forever = 1'b1;
            end
            else begin
                s1_next.trans_ms = sat_time(WIDE_BITS'(trans_prod));
            end
        end
    end

    // A set is taken unless it repeats the last identity or the stored value.
    assign is_set   = (s1_reg.mode == MODE_SET_ACK) || (s1_reg.mode == MODE_SET_UNACK);
    assign take_set = is_set
                      && !(s1_reg.transaction_id == last_tid_reg
                           && s1_reg.source_address == last_src_reg)
                      && (s1_reg.target_value != stored_value_reg);

    // Remaining time as seen after this transaction's set, if any.
    assign rem_sum = take_set
                     ? (TIME_BITS+1)'(s1_reg.delay_ms) + (TIME_BITS+1)'(s1_reg.trans_ms)
                     : (TIME_BITS+1)'(armed_reg ? count_reg : '0)
                       + (TIME_BITS+1)'(pending_reg);
    assign rem_ms  = sat_time(WIDE_BITS'(rem_sum));

    oswt_time_enc u_time_enc (
        .ms   (rem_ms),
        .code (rem_code)
    );

    always_comb begin
        stored_value_next = stored_value_reg;
        last_tid_next     = last_tid_reg;
        last_src_next     = last_src_reg;
        pending_next      = pending_reg;
        forever_next      = forever_reg;
        count_next        = count_reg;
        armed_next        = armed_reg;
        led_next          = led_reg;
        produce           = 1'b0;

        res_next.result_kind     = KIND_STATUS;
        res_next.present_value   = stored_value_reg;
        res_next.reported_target = stored_value_reg;
        res_next.has_remaining   = 1'b0;
        res_next.remaining_code  = '0;
        res_next.led_level       = led_reg;

        unique case (s1_reg.mode)
            MODE_TICK: begin
                if (armed_reg) begin
                    if (count_reg > TIME_BITS'(1)) begin
                        count_next = count_reg - TIME_BITS'(1);
                    end
                    else begin
                        produce    = 1'b1;
                        count_next = '0;
                        priority if (pending_reg != '0) begin
                            led_next     = 1'b1;
                            count_next   = pending_reg;
                            pending_next = '0;
                        end
                        else if (forever_reg) begin
                            led_next   = 1'b1;
                            armed_next = 1'b0;
                        end
                        else begin
                            led_next   = stored_value_reg;
                            armed_next = 1'b0;
                        end
                        res_next.result_kind = KIND_UPDATE;
                        res_next.led_level   = led_next;
                    end
                end
            end
            default: begin
                if (take_set) begin
                    stored_value_next = s1_reg.target_value;
                    last_tid_next     = s1_reg.transaction_id;
                    last_src_next     = s1_reg.source_address;
                    pending_next      = s1_reg.trans_ms;
                    forever_next      = s1_reg.is_forever;
                    count_next        = s1_reg.delay_ms;
                    armed_next        = 1'b1;
                end
                produce = (s1_reg.mode != MODE_SET_UNACK);
                res_next.reported_target = stored_value_next;
                if (forever_next) begin
                    res_next.has_remaining  = 1'b1;
                    res_next.remaining_code = CODE_FOREVER;
                    res_next.present_value  = !stored_value_next;
                end
                else if (rem_ms != '0) begin
                    res_next.has_remaining  = 1'b1;
                    res_next.remaining_code = rem_code;
                    res_next.present_value  = !stored_value_next;
                end
                else begin
                    res_next.present_value  = stored_value_next;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            stored_value_reg <= 1'b0;
            last_tid_reg     <= '0;
            last_src_reg     <= '0;
            pending_reg      <= '0;
            forever_reg      <= 1'b0;
            count_reg        <= '0;
            armed_reg        <= 1'b0;
            led_reg          <= 1'b0;
        end
        else begin
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg    <= produce;
                stored_value_reg <= stored_value_next;
                last_tid_reg     <= last_tid_next;
                last_src_reg     <= last_src_next;
                pending_reg      <= pending_next;
                forever_reg      <= forever_next;
                count_reg        <= count_next;
                armed_reg        <= armed_next;
                led_reg          <= led_next;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            s1_reg <= s1_next;
        end
        if (advance && produce) begin
            out_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // An idle timer never leaves a transition behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (pending_reg == '0))
        else $error("transition pending while the timer is idle");

    // A forever transition carries no timed transition.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(forever_reg && (pending_reg != '0)))
        else $error("forever and timed transition both set");

    // An LED update never carries a remaining time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind == KIND_UPDATE)
        |-> (!out_data.has_remaining && out_data.remaining_code == '0))
        else $error("update result with remaining time");

    // A status without remaining time reports the stored value as present.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind == KIND_STATUS && !out_data.has_remaining)
        |-> (out_data.remaining_code == '0
             && out_data.present_value == out_data.reported_target))
        else $error("inconsistent status without remaining time");

    // Input is held back only by a full input register behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a reason");
`endif

endmodule

[design/oswt_time_enc.sv]
// ----------------------------------------------------------------------------
// oswt_time_enc
// Encodes a millisecond time as a resolution and a rounded-up step count.
// ----------------------------------------------------------------------------
module oswt_time_enc (
    input  logic [oswt_pkg::TIME_BITS-1:0] ms,
    output logic [7:0]                     code
);
    import oswt_pkg::*;

    logic [1:0]                     res_sel;
    logic                           in_range;
    logic [ENC_BITS-1:0]            rounded;
    logic [RECIP_BITS-1:0]          recip;
    logic [ENC_BITS+RECIP_BITS-1:0] prod;
    logic [STEP_BITS-1:0]           steps;

    // Pick the finest resolution that keeps the time below 63 steps.
    always_comb begin
        in_range = 1'b1;
        res_sel  = 2'd0;
        priority if (WIDE_BITS'(ms) < ENC_LIMIT[0]) begin
            res_sel = 2'd0;
        end
        else if (WIDE_BITS'(ms) < ENC_LIMIT[1]) begin
            res_sel = 2'd1;
        end
        else if (WIDE_BITS'(ms) < ENC_LIMIT[2]) begin
            res_sel = 2'd2;
        end
        else if (WIDE_BITS'(ms) < ENC_LIMIT[3]) begin
            res_sel = 2'd3;
        end
        else begin
            res_sel  = 2'd3;
            in_range = 1'b0;
        end
    end

    // Round up by adding one step less one, then divide by reciprocal multiply.
    assign rounded = ENC_BITS'(ms) + ENC_BITS'(RES_MS[res_sel] - 32'd1);
    assign recip   = RECIP_FULL[res_sel][RECIP_BITS-1:0];
    assign prod    = (ENC_BITS+RECIP_BITS)'(rounded) * (ENC_BITS+RECIP_BITS)'(recip);

    always_comb begin
        unique case (res_sel)
            2'd0:    steps = prod[RES_SHIFT[0] +: STEP_BITS];
            2'd1:    steps = prod[RES_SHIFT[1] +: STEP_BITS];
            2'd2:    steps = prod[RES_SHIFT[2] +: STEP_BITS];
            default: steps = prod[RES_SHIFT[3] +: STEP_BITS];
        endcase
    end

    assign code = in_range ? {res_sel, steps} : CODE_FOREVER;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the on/off server with transition. A behavioral
// predictor of the server state computes each status and LED update, and a
// checker compares every output transaction with the oldest prediction.
// Directed tests cover the reset identity, idle ticks, delay and transition
// expiry, dropped sets, forever transitions and time encoding. Random set and
// tick sequences follow, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
    import oswt_pkg::*;

    typedef logic [63:0] wide_t;

    localparam wide_t STEP_MS [4] = '{64'd100, 64'd1000, 64'd10000, 64'd600000};
    localparam wide_t TIME_CAP = (64'd1 << TIME_BITS) - 64'd1;
    localparam int unsigned RANDOM_ITEMS = 2000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    item_in_t in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    result_t  out_data;

    // Predicted server state.
    logic                 srv_value;
    logic [7:0]           srv_tid;
    logic [15:0]          srv_src;
    logic [TIME_BITS-1:0] srv_pending;
    logic                 srv_forever;
    logic [TIME_BITS-1:0] srv_timer;
    logic                 srv_armed;
    logic                 srv_led;

    result_t     awaited_results [$];
    int unsigned fail_count = 0;
    int unsigned active_items = 0;

    // Traffic shaping.
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    int unsigned burst_left = 0;
    bit          ready_phase = 1'b0;
    int unsigned ready_run = 0;

    onoff_server_with_transition u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TIME_BITS-1:0] clamp_ms(input wide_t v);
        return (v > TIME_CAP) ? TIME_CAP[TIME_BITS-1:0] : v[TIME_BITS-1:0];
    endfunction

    // The finest resolution under which the time stays below 63 steps wins.
    function automatic logic [7:0] encode_remaining(input logic [TIME_BITS-1:0] ms);
        logic [7:0] code;
        wide_t      m;
        wide_t      steps;
        code = CODE_FOREVER;
        m = wide_t'(ms);
        for (int i = 3; i >= 0; i--)
        begin
            if (m < wide_t'(STEP_FOREVER) * STEP_MS[i])
            begin
                steps = (m + STEP_MS[i] - 64'd1) / STEP_MS[i];
                code = {2'(i), steps[5:0]};
            end
        end
        return code;
    endfunction

    function automatic item_in_t make_item(input mode_t mode, input logic value,
                                           input logic [7:0] tid, input logic [15:0] src,
                                           input logic timing, input logic [7:0] tcode,
                                           input logic [7:0] dcode);
        item_in_t it;
        it.mode = mode;
        it.target_value = value;
        it.transaction_id = tid;
        it.source_address = src;
        it.has_timing = timing;
        it.transition_code = tcode;
        it.delay_code = dcode;
        return it;
    endfunction

    task automatic server_reset();
        srv_value = 1'b0;
        srv_tid = '0;
        srv_src = '0;
        srv_pending = '0;
        srv_forever = 1'b0;
        srv_timer = '0;
        srv_armed = 1'b0;
        srv_led = 1'b0;
    endtask

    // Advances the predicted state by one accepted transaction and queues the
    // result it causes. acted is set when the item changed or reported anything.
    task automatic server_step(input item_in_t it, output bit acted);
        result_t              r;
        bit                   emit;
        bit                   forever_req;
        bit                   has;
        logic [7:0]           code;
        logic [TIME_BITS-1:0] trans_ms;
        logic [TIME_BITS-1:0] delay_ms;
        logic [TIME_BITS-1:0] rem;
        r = '0;
        emit = 1'b0;
        acted = 1'b0;
        if (it.mode == MODE_TICK)
        begin
            if (srv_armed)
            begin
                acted = 1'b1;
                if (srv_timer > 1)
                begin
                    srv_timer = srv_timer - 1'b1;
                end
                else
                begin
                    srv_timer = '0;
                    if (srv_pending != 0)
                    begin
                        srv_led = 1'b1;
                        srv_timer = srv_pending;
                        srv_pending = '0;
                    end
                    else if (srv_forever)
                    begin
                        srv_led = 1'b1;
                        srv_armed = 1'b0;
                    end
                    else
                    begin
                        srv_led = srv_value;
                        srv_armed = 1'b0;
                    end
                    emit = 1'b1;
                    r.result_kind = KIND_UPDATE;
                    r.present_value = srv_value;
                    r.reported_target = srv_value;
                    r.led_level = srv_led;
                end
            end
        end
        else
        begin
            if (it.mode != MODE_GET)
            begin
                trans_ms = '0;
                delay_ms = '0;
                forever_req = 1'b0;
                if (it.has_timing)
                begin
                    if (it.transition_code[5:0] == STEP_FOREVER)
                    begin
                        forever_req = 1'b1;
                    end
                    else
                    begin
                        trans_ms = clamp_ms(wide_t'(it.transition_code[5:0])
                                            * STEP_MS[it.transition_code[7:6]]);
                    end
                    delay_ms = clamp_ms(wide_t'(it.delay_code) * 64'd5);
                end
                // A repeated identity or an unchanged value leaves the state alone.
                if (!(it.transaction_id == srv_tid && it.source_address == srv_src)
                    && it.target_value != srv_value)
                begin
                    acted = 1'b1;
                    srv_tid = it.transaction_id;
                    srv_src = it.source_address;
                    srv_value = it.target_value;
                    srv_pending = trans_ms;
                    srv_forever = forever_req;
                    srv_timer = delay_ms;
                    srv_armed = 1'b1;
                end
            end
            if (it.mode != MODE_SET_UNACK)
            begin
                has = 1'b0;
                code = '0;
                if (srv_forever)
                begin
                    has = 1'b1;
                    code = CODE_FOREVER;
                end
                else
                begin
                    rem = clamp_ms(wide_t'(srv_armed ? srv_timer : '0) + wide_t'(srv_pending));
                    if (rem != 0)
                    begin
                        has = 1'b1;
                        code = encode_remaining(rem);
                    end
                end
                emit = 1'b1;
                r.result_kind = KIND_STATUS;
                r.present_value = has ? ~srv_value : srv_value;
                r.reported_target = srv_value;
                r.has_remaining = has;
                r.remaining_code = code;
                r.led_level = srv_led;
            end
        end
        if (emit)
        begin
            awaited_results.push_back(r);
            acted = 1'b1;
        end
    endtask

    // Offers one transaction, with a random gap at the start of each burst.
    task automatic send_item(input item_in_t it);
        int unsigned gap;
        bit          acted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        server_step(it, acted);
        if (acted)
        begin
            active_items++;
        end
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(make_item(MODE_TICK, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00));
    endtask

    task automatic send_get();
        send_item(make_item(MODE_GET, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00));
    endtask

    task automatic check_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name,
                     expected, actual);
            fail_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual %0h", $realtime, got);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("result_kind", want.result_kind, got.result_kind);
            check_field("present_value", want.present_value, got.present_value);
            check_field("reported_target", want.reported_target, got.reported_target);
            check_field("has_remaining", want.has_remaining, got.has_remaining);
            check_field("remaining_code", want.remaining_code, got.remaining_code);
            check_field("led_level", want.led_level, got.led_level);
        end
    endtask

    // Output side: checks every accepted result and, while receiver_stalls is set, stalls in random runs.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result(out_data);
        end
        if (!receiver_stalls)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            if (ready_run == 0)
            begin
                ready_phase = !ready_phase;
                ready_run = ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 4);
            end
            ready_run--;
            out_ready <= ready_phase;
        end
    end

    // Transaction 0 from address 0 matches the identity left by reset.
    task automatic test_reset_identity();
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00));
        send_get();
    endtask

    task automatic test_idle_tick();
        send_ticks(1);
        send_get();
    endtask

    // Expiry from a count of zero and from a count of one.
    task automatic test_delay_expiry();
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h01, 16'h1234, 1'b0, 8'hc5, 8'h99));
        send_ticks(1);
        send_item(make_item(MODE_SET_UNACK, 1'b0, 8'h02, 16'h1234, 1'b1, 8'h00, 8'h01));
        send_get();
        send_ticks(5);
    endtask

    task automatic test_dropped_sets();
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h02, 16'h1234, 1'b0, 8'h00, 8'h00));
        send_item(make_item(MODE_SET_UNACK, 1'b0, 8'h03, 16'hffff, 1'b1, 8'h01, 8'h01));
        send_get();
    endtask

    task automatic test_transition_start();
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h04, 16'hffff, 1'b1, 8'h01, 8'h00));
        send_ticks(1);
        send_get();
    endtask

    task automatic test_forever();
        send_item(make_item(MODE_SET_ACK, 1'b0, 8'hff, 16'h8000, 1'b1, 8'h3f, 8'h00));
        send_ticks(1);
        send_get();
    endtask

    // Codes near the top of the three coarser resolutions, and a set with no timing bytes.
    task automatic test_time_encoding();
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h06, 16'h00ff, 1'b1, 8'hfe, 8'hff));
        send_item(make_item(MODE_SET_ACK, 1'b0, 8'h07, 16'h00ff, 1'b1, 8'h7e, 8'h00));
        send_item(make_item(MODE_SET_ACK, 1'b1, 8'h08, 16'h00ff, 1'b1, 8'hbe, 8'hff));
        send_item(make_item(MODE_SET_ACK, 1'b0, 8'h09, 16'h0000, 1'b0, 8'hff, 8'hff));
        send_ticks(1);
    endtask

    // Mostly a fresh set followed by enough ticks to see it through, with gets
    // in between; the rest is fully random traffic, partly repeating identities.
    task automatic test_random_traffic();
        item_in_t    it;
        int unsigned pick;
        int unsigned tick_run;
        int unsigned noise_len;
        while (active_items < RANDOM_ITEMS)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 60)
            begin
                it.mode = $urandom_range(0, 1) ? MODE_SET_ACK : MODE_SET_UNACK;
                it.target_value = ($urandom_range(0, 99) < 85) ? ~srv_value : srv_value;
                it.transaction_id = 8'($urandom);
                it.source_address = $urandom_range(0, 1) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 7));
                it.has_timing = ($urandom_range(0, 99) < 80);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    it.transition_code = {2'($urandom), 6'd0};
                end
                else if (pick < 75)
                begin
                    it.transition_code = 8'h01;
                end
                else if (pick < 85)
                begin
                    it.transition_code = {2'($urandom), STEP_FOREVER};
                end
                else
                begin
                    it.transition_code = 8'($urandom);
                end
                it.delay_code = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 6))
                                                              : 8'($urandom);
                tick_run = $urandom_range(1, 4);
                if (it.has_timing)
                begin
                    tick_run += it.delay_code * 5 + ((it.transition_code == 8'h01) ? 100 : 0);
                end
                if (tick_run > 150)
                begin
                    tick_run = $urandom_range(0, 20);
                end
                send_item(it);
                repeat (tick_run)
                begin
                    if ($urandom_range(0, 99) < 8)
                    begin
                        send_get();
                    end
                    send_ticks(1);
                end
            end
            else
            begin
                noise_len = $urandom_range(1, 8);
                repeat (noise_len)
                begin
                    it.mode = mode_t'($urandom_range(0, 3));
                    it.target_value = 1'($urandom);
                    it.transaction_id = 8'($urandom);
                    it.source_address = 16'($urandom);
                    it.has_timing = 1'($urandom);
                    it.transition_code = 8'($urandom);
                    it.delay_code = 8'($urandom);
                    if ($urandom_range(0, 99) < 20)
                    begin
                        it.transaction_id = srv_tid;
                        it.source_address = srv_src;
                    end
                    send_item(it);
                end
            end
        end
    endtask

    initial
    begin
        server_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_identity();
        test_idle_tick();
        test_delay_expiry();
        test_dropped_sets();
        test_transition_start();
        test_forever();
        test_time_encoding();
        active_items = 0;
        test_random_traffic();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[files.f]
design/oswt_pkg.sv
design/oswt_time_enc.sv
design/onoff_server_with_transition.sv
tb/tb.sv
